>>> hw/rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// assert_macros.svh
// Assertion helpers used by the checker file.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, muted while reset is high.
`define ASSERT_CLK(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");

// Clocked property that also holds during reset.
`define ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("assertion failed");

`endif

>>> hw/rtl/bfa_pkg.sv
// ---------------------------------------------------------------------------
// bfa_pkg
// Types and constants of the best fit range allocator.
// ---------------------------------------------------------------------------
`default_nettype none

package bfa_pkg;

   // Slot map storage: slots per memory word.
   localparam int WORD_BITS = 8;
   localparam int WORD_LOG  = 3;

   localparam int SLOTS_DEF = 1024;

   localparam logic [10:0] TOTAL_RST = 11'd1024;
   localparam logic [15:0] REJ_MAX   = 16'hFFFF;

   // Request kinds
   localparam logic CMD_ALLOC   = 1'b0;
   localparam logic CMD_RELEASE = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_FLUSH,
      ST_FILL,
      ST_DONE
   } bfa_state_type;

endpackage

`default_nettype wire

>>> hw/rtl/best_fit_range_allocator_top.sv
// ---------------------------------------------------------------------------
// best_fit_range_allocator_top
// Best fit contiguous slot allocator over a slot map held in memory words.
// ---------------------------------------------------------------------------
// Usage:
//   req_* carries one request per beat: allocate a run (req_tuser low) or
//   release an inclusive range (req_tuser high). rsp_* returns one beat per
//   request: grant flag, start slot and the saturating rejection count.
//   csr_* writes total_slots; a write also marks every slot free again.
// Operation:
//   The slot map lives in words of 8 slots with a registered read. An allocate
//   scans every word in use, one per cycle, then rewrites the words of the
//   chosen run before the result beat is posted. A release rewrites the words
//   of its range; a request that needs no memory access goes straight to the
//   result. One request is in work at a time; req_tready is high only when
//   idle, so the next request beat can be taken in the cycle after a result
//   is posted.
// Reset:
//   All slots free, total_slots = 1024, count zero. Per-word valid flags make
//   unwritten words read as free, so no clearing pass runs.
// Stall:
//   A finished result sits in the output register; the next request is taken
//   meanwhile and waits at its end until the output register is free.
// ---------------------------------------------------------------------------
`default_nettype none

module best_fit_range_allocator_top
   import bfa_pkg::*;
#(
   parameter int SLOTS = SLOTS_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // request stream
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [31:0] req_tdata,   // request_size[10:0], range_first[20:11],
                                         // range_last[30:21], zero[31]
   input  wire logic        req_tuser,   // command
   // result stream
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [31:0]      rsp_tdata,   // start_slot[9:0], rejected_total[25:10],
                                         // zero[31:26]
   output logic             rsp_tuser,   // granted
   // register port
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [1:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready
);

   localparam int NWORDS = (SLOTS + WORD_BITS - 1) / WORD_BITS;
   localparam int AW     = (NWORDS > 1) ? $clog2(NWORDS) : 1;
   localparam int LW     = ($clog2(SLOTS) + 1 > 11) ? $clog2(SLOTS) + 1 : 11;

   bfa_state_type state_ff, state_in;

   logic [10:0]          total_ff;
   logic [15:0]          rej_ff, rej_in;
   logic [LW-1:0]        want_ff, want_in;
   logic [LW-1:0]        lo_ff, lo_in, hi_ff, hi_in;
   logic                 fill_ff, fill_in;
   logic [LW-1:0]        addr_ff, addr_in, end_ff, end_in;
   logic                 pend_ff, pend_in;
   logic [LW-1:0]        pend_addr_ff, pend_addr_in;
   logic [LW-1:0]        run_at_ff, run_at_in, run_len_ff, run_len_in;
   logic [LW-1:0]        best_at_ff, best_at_in, best_len_ff, best_len_in;
   logic                 found_ff, found_in;
   logic                 res_grant_ff, res_grant_in;
   logic [9:0]           res_start_ff, res_start_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 rsp_grant_ff, rsp_grant_in;
   logic [9:0]           rsp_start_ff, rsp_start_in;
   logic [15:0]          rsp_rej_ff, rsp_rej_in;

   logic [WORD_BITS-1:0] mem [NWORDS];
   logic [WORD_BITS-1:0] rd_data_ff;
   logic [NWORDS-1:0]    word_vld_ff;

   logic                 mem_we;
   logic [WORD_BITS-1:0] mem_wdata;
   logic [AW-1:0]        pidx;
   logic [WORD_BITS-1:0] word_data;
   logic                 issue;
   logic                 csr_we;
   logic                 req_fire;
   logic [LW-1:0]        n_lim;
   logic [LW-1:0]        base;

   // scan results for the word in hand
   logic [LW-1:0]        sc_run_at, sc_run_len, sc_best_at, sc_best_len;
   logic                 sc_found;
   logic [WORD_BITS-1:0] fill_word;
   logic                 close_hit;

   logic [10:0]          in_size;
   logic [LW-1:0]        in_first, in_last;

   assign csr_pready = 1'b1;
   assign csr_we     = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign csr_prdata = {21'd0, total_ff};

   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid & req_tready;
   assign in_size    = req_tdata[10:0];
   assign in_first   = LW'(req_tdata[20:11]);
   assign in_last    = LW'(req_tdata[30:21]);

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_grant_ff;
   assign rsp_tdata  = {6'd0, rsp_rej_ff, rsp_start_ff};

   // Clamp the slot count into 1..SLOTS
   always_comb begin
      if (total_ff == 11'd0) begin
         n_lim = LW'(1);
      end else if (LW'(total_ff) > LW'(SLOTS)) begin
         n_lim = LW'(SLOTS);
      end else begin
         n_lim = LW'(total_ff);
      end
   end

   // Word in hand; a never written word reads as all free
   assign pidx      = pend_addr_ff[AW-1:0];
   assign word_data = word_vld_ff[pidx] ? rd_data_ff : '1;
   assign base      = pend_addr_ff << WORD_LOG;
   assign issue     = (addr_ff <= end_ff);

   // Run tracking over the eight slots of one word
   always_comb begin : scan_word
      logic [LW-1:0] s;
      logic          is_free;
      sc_run_at   = run_at_ff;
      sc_run_len  = run_len_ff;
      sc_best_at  = best_at_ff;
      sc_best_len = best_len_ff;
      sc_found    = found_ff;
      fill_word   = word_data;
      for (int i = 0; i < WORD_BITS; i++) begin
         s       = base + LW'(i);
         is_free = word_data[i] && (s < n_lim);
         if (is_free) begin
            if (sc_run_len == '0) begin
               sc_run_at = s;
            end
            sc_run_len = sc_run_len + LW'(1);
         end else if (sc_run_len != '0) begin
            if (sc_run_len >= want_ff && (!sc_found || sc_run_len < sc_best_len)) begin
               sc_found    = 1'b1;
               sc_best_len = sc_run_len;
               sc_best_at  = sc_run_at;
            end
            sc_run_len = '0;
         end
         if (s >= lo_ff && s <= hi_ff) begin
            fill_word[i] = fill_ff;
         end
      end
   end

   // Close the run still open at the end of the map
   assign close_hit = (run_len_ff != '0) && (run_len_ff >= want_ff) &&
                      (!found_ff || run_len_ff < best_len_ff);

   // Next state and datapath control
   always_comb begin
      state_in     = state_ff;
      rej_in       = rej_ff;
      want_in      = want_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      fill_in      = fill_ff;
      addr_in      = addr_ff;
      end_in       = end_ff;
      pend_in      = pend_ff;
      pend_addr_in = pend_addr_ff;
      run_at_in    = run_at_ff;
      run_len_in   = run_len_ff;
      best_at_in   = best_at_ff;
      best_len_in  = best_len_ff;
      found_in     = found_ff;
      res_grant_in = res_grant_ff;
      res_start_in = res_start_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_grant_in = rsp_grant_ff;
      rsp_start_in = rsp_start_ff;
      rsp_rej_in   = rsp_rej_ff;
      mem_we       = 1'b0;
      mem_wdata    = fill_word;

      // drop the result once taken
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               res_grant_in = 1'b0;
               res_start_in = '0;
               pend_in      = 1'b0;
               if (req_tuser == CMD_ALLOC) begin
                  want_in     = LW'(in_size);
                  addr_in     = '0;
                  end_in      = (n_lim - LW'(1)) >> WORD_LOG;
                  run_at_in   = '0;
                  run_len_in  = '0;
                  best_at_in  = '0;
                  best_len_in = '0;
                  found_in    = 1'b0;
                  lo_in       = '1;
                  hi_in       = '0;
                  if (in_size == 11'd0) begin
                     rej_in   = (rej_ff == REJ_MAX) ? rej_ff : rej_ff + 16'd1;
                     state_in = ST_DONE;
                  end else begin
                     state_in = ST_SCAN;
                  end
               end else if (in_first <= in_last && in_first < n_lim) begin
                  lo_in    = in_first;
                  hi_in    = (in_last >= n_lim) ? n_lim - LW'(1) : in_last;
                  addr_in  = in_first >> WORD_LOG;
                  end_in   = ((in_last >= n_lim) ? n_lim - LW'(1) : in_last) >> WORD_LOG;
                  fill_in  = 1'b1;
                  state_in = ST_FILL;
               end else begin
                  state_in = ST_DONE;
               end
            end
         end

         ST_SCAN: begin
            pend_in      = issue;
            pend_addr_in = addr_ff;
            if (issue) begin
               addr_in = addr_ff + LW'(1);
            end
            if (pend_ff) begin
               run_at_in   = sc_run_at;
               run_len_in  = sc_run_len;
               best_at_in  = sc_best_at;
               best_len_in = sc_best_len;
               found_in    = sc_found;
            end
            if (!issue && !pend_ff) begin
               state_in = ST_FLUSH;
            end
         end

         ST_FLUSH: begin
            if (found_ff || close_hit) begin
               lo_in        = close_hit ? run_at_ff : best_at_ff;
               hi_in        = (close_hit ? run_at_ff : best_at_ff) + want_ff - LW'(1);
               addr_in      = (close_hit ? run_at_ff : best_at_ff) >> WORD_LOG;
               end_in       = ((close_hit ? run_at_ff : best_at_ff) + want_ff - LW'(1))
                              >> WORD_LOG;
               fill_in      = 1'b0;
               pend_in      = 1'b0;
               res_grant_in = 1'b1;
               res_start_in = close_hit ? run_at_ff[9:0] : best_at_ff[9:0];
               state_in     = ST_FILL;
            end else begin
               rej_in   = (rej_ff == REJ_MAX) ? rej_ff : rej_ff + 16'd1;
               state_in = ST_DONE;
            end
         end

         ST_FILL: begin
            pend_in      = issue;
            pend_addr_in = addr_ff;
            if (issue) begin
               addr_in = addr_ff + LW'(1);
            end
            if (pend_ff) begin
               mem_we = 1'b1;
            end
            if (!issue && !pend_ff) begin
               state_in = ST_DONE;
            end
         end

         ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_grant_in = res_grant_ff;
               rsp_start_in = res_start_ff;
               rsp_rej_in   = rej_ff;
               state_in     = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Slot map memory: one write, one registered read per cycle
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[pidx] <= mem_wdata;
      end
      rd_data_ff <= mem[addr_ff[AW-1:0]];
   end

   // Word valid flags: clear on reset and on a slot count write
   always_ff @(posedge clock) begin
      if (reset || csr_we) begin
         word_vld_ff <= '0;
      end else if (mem_we) begin
         word_vld_ff[pidx] <= 1'b1;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         total_ff     <= TOTAL_RST;
         rej_ff       <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rej_ff       <= rej_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            total_ff <= csr_pwdata[10:0];
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      want_ff      <= want_in;
      lo_ff        <= lo_in;
      hi_ff        <= hi_in;
      fill_ff      <= fill_in;
      addr_ff      <= addr_in;
      end_ff       <= end_in;
      pend_addr_ff <= pend_addr_in;
      run_at_ff    <= run_at_in;
      run_len_ff   <= run_len_in;
      best_at_ff   <= best_at_in;
      best_len_ff  <= best_len_in;
      found_ff     <= found_in;
      res_grant_ff <= res_grant_in;
      res_start_ff <= res_start_in;
      rsp_grant_ff <= rsp_grant_in;
      rsp_start_ff <= rsp_start_in;
      rsp_rej_ff   <= rsp_rej_in;
   end

   // csr_paddr is not decoded: every word address maps to the single register
   logic unused_paddr;
   assign unused_paddr = ^csr_paddr;

endmodule

`default_nettype wire

>>> hw/rtl/bfa_checker.sv
// ---------------------------------------------------------------------------
// bfa_checker
// Port level checks of the allocator, bound to the top level.
// ---------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module bfa_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_tvalid,
   input wire logic        req_tready,
   input wire logic [31:0] req_tdata,
   input wire logic        req_tuser,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [31:0] rsp_tdata,
   input wire logic        rsp_tuser,
   input wire logic        csr_psel,
   input wire logic        csr_penable,
   input wire logic        csr_pwrite,
   input wire logic [1:0]  csr_paddr,
   input wire logic [31:0] csr_pwdata,
   input wire logic [31:0] csr_prdata,
   input wire logic        csr_pready
);

   // A stalled result beat holds
   `ASSERT_CLK(a_rsp_hold, clock, reset,
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))

   // One request at a time: an accepted beat closes the input
   `ASSERT_CLK(a_req_busy, clock, reset, req_tvalid && req_tready |=> !req_tready)

   // Reset leaves no result pending
   `ASSERT_ALWAYS(a_rst_empty, clock, reset |=> !rsp_tvalid)

   // A refused allocation reports start slot zero
   `ASSERT_CLK(a_no_grant_zero, clock, reset,
      rsp_tvalid && !rsp_tuser |-> rsp_tdata[9:0] == 10'd0)

endmodule

bind best_fit_range_allocator_top bfa_checker u_bfa_checker (.*);

`default_nettype wire
